// File: hdl/afc_pkg.sv
// ----------------------------------------------------------------------------
// afc_pkg
// Types, codes and helper functions for the animation frame counter. All
// positions, rates and distances are Q16.16 two's complement.
// ----------------------------------------------------------------------------
package afc_pkg;

    // stream payload widths
    localparam int S_TDATA_W = 72;   // play_mode, speed, value, zero pad
    localparam int S_TUSER_W = 4;    // req_type
    localparam int M_TDATA_W = 40;   // frame, at_end, turned_at_end, turned_at_start, pad
    localparam int RANGE_W   = 31;

    // configuration register indexes
    localparam logic CFG_RANGE_START = 1'b0;
    localparam logic CFG_RANGE_END   = 1'b1;

    // status flag bit positions
    localparam int FLAG_AT_END     = 0;
    localparam int FLAG_TURN_END   = 1;
    localparam int FLAG_TURN_START = 2;

    // remaining distance after reset and after play commands without a distance limit: -1.0
    localparam logic [31:0] REM_NONE = 32'hFFFF_0000;

    typedef enum logic [3:0] {
        REQ_TICK       = 4'd0,
        REQ_PLAY       = 4'd1,
        REQ_PLAY_CUR   = 4'd2,
        REQ_PLAY_DIST  = 4'd3,
        REQ_PLAY_TGT   = 4'd4,
        REQ_STOP_HERE  = 4'd5,
        REQ_STOP_END   = 4'd6,
        REQ_STOP_AT    = 4'd7,
        REQ_SET_FRAME  = 4'd8
    } req_t;

    typedef enum logic [1:0] {
        MODE_ONESHOT  = 2'd0,
        MODE_LOOP     = 2'd1,
        MODE_PINGPONG = 2'd2
    } mode_t;

    // one accepted request
    typedef struct packed {
        req_t        req;
        mode_t       play_mode;
        logic [31:0] speed;
        logic [31:0] value;
    } afc_item_t;

    // counter state
    typedef struct packed {
        logic [31:0] pos;
        logic [31:0] rate;
        logic [31:0] rem;
        logic        dist_lim;
        mode_t       mode;
        logic [2:0]  flags;
    } afc_state_t;

    // sign extend a 32-bit value to the working width
    function automatic logic signed [33:0] sx(input logic [31:0] v);
        return $signed({{2{v[31]}}, v});
    endfunction

    // zero extend a range register to the working width
    function automatic logic signed [33:0] zx(input logic [RANGE_W-1:0] v);
        return $signed({3'b000, v});
    endfunction

    // saturate a working-width value to 32 bits
    function automatic logic [31:0] sat32(input logic signed [33:0] v);
        logic [31:0] r;
        if (v[33:31] == 3'b000 || v[33:31] == 3'b111) begin
            r = v[31:0];
        end else if (v[33]) begin
            r = 32'h8000_0000;
        end else begin
            r = 32'h7FFF_FFFF;
        end
        return r;
    endfunction

    // negate, most negative maps to most positive
    function automatic logic [31:0] neg32(input logic [31:0] v);
        return sat32(-sx(v));
    endfunction

    // apply the end or start edge rule of the current mode
    function automatic afc_state_t apply_edge(input afc_state_t s, input logic end_side,
                                              input logic [RANGE_W-1:0] rs,
                                              input logic [RANGE_W-1:0] re);
        afc_state_t        r;
        logic signed [33:0] p;
        logic signed [33:0] rs_x;
        logic signed [33:0] re_x;
        r    = s;
        p    = sx(s.pos);
        rs_x = zx(rs);
        re_x = zx(re);
        case (s.mode)
            MODE_ONESHOT: begin
                r.pos = end_side ? re_x[31:0] : rs_x[31:0];
                r.flags[FLAG_AT_END] = 1'b1;
            end
            MODE_LOOP: begin
                if (end_side) begin
                    r.pos = sat32(rs_x + p - re_x);
                    r.flags[FLAG_TURN_END] = 1'b1;
                end else begin
                    r.pos = re_x[31:0];
                    r.flags[FLAG_TURN_START] = 1'b1;
                end
            end
            MODE_PINGPONG: begin
                if (end_side) begin
                    r.pos = sat32(re_x + re_x - p);
                    r.flags[FLAG_TURN_END] = 1'b1;
                end else begin
                    r.pos = sat32(rs_x - p);
                    r.flags[FLAG_TURN_START] = 1'b1;
                end
                r.rate = neg32(s.rate);
            end
            default: begin
                r = s;
            end
        endcase
        return r;
    endfunction

endpackage

// File: hdl/afc_in_stage.sv
// ----------------------------------------------------------------------------
// afc_in_stage
// Input register of the request stream; holds one request until the
// update stage takes it.
// ----------------------------------------------------------------------------
module afc_in_stage (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [afc_pkg::S_TDATA_W-1:0]  s_tdata,
    input  logic [afc_pkg::S_TUSER_W-1:0]  s_tuser,
    input  logic                           advance,
    output logic                           item_valid,
    output afc_pkg::afc_item_t             item
);
    import afc_pkg::*;

    logic      valid_reg;
    logic      valid_next;
    afc_item_t item_reg;

    // free slot, or the held word leaves this cycle
    assign s_tready   = !valid_reg || advance;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    // occupancy
    always_comb begin
        valid_next = valid_reg;
        if (s_tvalid && s_tready) begin
            valid_next = 1'b1;
        end else if (advance) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // payload capture
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            item_reg.req       <= req_t'(s_tuser);
            item_reg.play_mode <= mode_t'(s_tdata[1:0]);
            item_reg.speed     <= s_tdata[33:2];
            item_reg.value     <= s_tdata[65:34];
        end
    end

endmodule

// File: hdl/afc_step.sv
// ----------------------------------------------------------------------------
// afc_step
// Next counter state for one request: tick advance with distance limit,
// edge rules, play, stop and set-frame commands.
// ----------------------------------------------------------------------------
module afc_step (
    input  afc_pkg::afc_state_t             cur,
    input  afc_pkg::afc_item_t              item,
    input  logic [afc_pkg::RANGE_W-1:0]     range_start,
    input  logic [afc_pkg::RANGE_W-1:0]     range_end,
    output afc_pkg::afc_state_t             nxt
);
    import afc_pkg::*;

    afc_state_t         mv;
    afc_state_t         e1;
    afc_state_t         e2;
    afc_state_t         cmd;
    logic signed [33:0] pos_x;
    logic signed [33:0] rate_x;
    logic signed [33:0] rem_x;
    logic signed [33:0] rs_x;
    logic signed [33:0] re_x;
    logic signed [33:0] diff;
    logic signed [33:0] mag;
    logic signed [33:0] tgt_d;
    logic [31:0]        tgt_r;
    logic               rate_zero;
    logic               rate_pos;

    assign pos_x  = sx(cur.pos);
    assign rate_x = sx(cur.rate);
    assign rem_x  = sx(cur.rem);
    assign rs_x   = zx(range_start);
    assign re_x   = zx(range_end);

    // tick: move, honoring the distance limit
    always_comb begin
        mv       = cur;
        mv.flags = 3'b000;
        diff     = rem_x - rate_x;
        mag      = rate_x[33] ? -rate_x : rate_x;
        if (!cur.dist_lim) begin
            mv.pos = sat32(pos_x + rate_x);
        end else if (!cur.rem[31] && cur.rem != 32'd0) begin
            if (diff[33]) begin
                mv.pos = sat32(pos_x + rem_x);
                mv.rem = 32'd0;
            end else begin
                mv.rem = sat32(rem_x - mag);
                mv.pos = sat32(pos_x + rate_x);
            end
        end
    end

    // tick: zero-rate edge check, then the rate-directed check
    always_comb begin
        rate_zero = (mv.rate == 32'd0);
        if (rate_zero) begin
            e1 = apply_edge(mv, sx(mv.pos) >= re_x, range_start, range_end);
        end else begin
            e1 = mv;
        end
        rate_pos = !e1.rate[31] && e1.rate != 32'd0;
        e2 = e1;
        if (rate_pos) begin
            if (sx(e1.pos) >= re_x) begin
                e2 = apply_edge(e1, 1'b1, range_start, range_end);
            end
        end else begin
            if (sx(e1.pos) < rs_x) begin
                e2 = apply_edge(e1, 1'b0, range_start, range_end);
            end
        end
    end

    // play-to-target distance, wrapped once by the range length
    always_comb begin
        if (!item.speed[31] && item.speed != 32'd0) begin
            tgt_d = sx(item.value) - pos_x;
        end else begin
            tgt_d = pos_x - sx(item.value);
        end
        tgt_r = sat32(tgt_d);
        if (tgt_r[31]) begin
            tgt_r = sat32(sx(tgt_r) + (re_x - rs_x));
        end
    end

    // command decode
    always_comb begin
        cmd = cur;
        unique case (item.req) inside
            REQ_TICK: begin
                cmd = e2;
            end
            REQ_PLAY, REQ_PLAY_CUR, REQ_PLAY_DIST, REQ_PLAY_TGT: begin
                cmd.mode     = item.play_mode;
                cmd.rate     = item.speed;
                cmd.dist_lim = 1'b0;
                cmd.rem      = REM_NONE;
                cmd.flags    = 3'b000;
                if (item.req == REQ_PLAY) begin
                    cmd.pos = item.speed[31] ? re_x[31:0] : rs_x[31:0];
                end else if (item.req == REQ_PLAY_DIST) begin
                    cmd.rem      = item.value;
                    cmd.dist_lim = 1'b1;
                end else if (item.req == REQ_PLAY_TGT) begin
                    cmd.rem      = tgt_r;
                    cmd.dist_lim = 1'b1;
                end
            end
            REQ_STOP_HERE: begin
                cmd.flags = 3'b000;
                cmd.rate  = 32'd0;
            end
            REQ_STOP_END: begin
                cmd.rate  = 32'd0;
                cmd.pos   = re_x[31:0];
                cmd.flags = 3'b000;
                cmd.flags[FLAG_AT_END] = 1'b1;
            end
            REQ_STOP_AT: begin
                cmd.pos   = item.value;
                cmd.rate  = 32'd0;
                cmd.flags = 3'b000;
            end
            REQ_SET_FRAME: begin
                cmd.flags = 3'b000;
                cmd.pos   = item.value;
            end
            default: begin
                cmd = cur;
            end
        endcase
    end

    assign nxt = cmd;

endmodule

// File: hdl/animation_frame_counter_top.sv
// ----------------------------------------------------------------------------
// animation_frame_counter_top
// Fractional Q16.16 frame counter with one-shot, loop and ping-pong play.
//
//   channel   dir  handshake          payload
//   s_        in   s_tvalid/s_tready  s_tdata: play_mode, speed, value
//                                     s_tuser: req_type
//   m_        out  m_tvalid/m_tready  m_tdata: frame, status flags
//   cfg_      in   cfg_we             cfg_index, cfg_wdata (range start/end)
//
// One request per cycle sustained while m_ does not stall; each request's
// result word passes the input register, then the state and result
// register, and is then valid on m_. The state update for a request is
// combinational, so the next request sees it at once.
// Reset is synchronous, active low; it clears the state and both range
// registers. A stalled m_ side holds the result and the input register;
// the s_ side keeps accepting while the input register can drain.
// ----------------------------------------------------------------------------
module animation_frame_counter_top (
    input  logic                           aclk,
    input  logic                           aresetn,
    // request stream
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // [1:0] play_mode, [33:2] speed, [65:34] value, [71:66] zero
    input  logic [afc_pkg::S_TDATA_W-1:0]  s_tdata,
    // [3:0] req_type
    input  logic [afc_pkg::S_TUSER_W-1:0]  s_tuser,
    // result stream
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // [31:0] frame, [32] at_end, [33] turned_at_end, [34] turned_at_start,
    // [39:35] zero
    output logic [afc_pkg::M_TDATA_W-1:0]  m_tdata,
    // configuration writes
    input  logic                           cfg_we,
    input  logic                           cfg_index,
    input  logic [afc_pkg::RANGE_W-1:0]    cfg_wdata
);
    import afc_pkg::*;

    logic                 item_valid;
    afc_item_t            item;
    logic                 advance;
    afc_state_t           state_reg;
    afc_state_t           state_next;
    logic [RANGE_W-1:0]   range_start_reg;
    logic [RANGE_W-1:0]   range_end_reg;
    logic                 out_valid_reg;
    logic                 out_valid_next;
    logic [M_TDATA_W-1:0] out_data_reg;

    // the held request moves on when the result register is free
    assign advance = item_valid && (!out_valid_reg || m_tready);

    afc_in_stage u_in_stage (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .advance    (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    afc_step u_step (
        .cur         (state_reg),
        .item        (item),
        .range_start (range_start_reg),
        .range_end   (range_end_reg),
        .nxt         (state_next)
    );

    // range registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            range_start_reg <= '0;
            range_end_reg   <= '0;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_RANGE_START: range_start_reg <= cfg_wdata;
                CFG_RANGE_END:   range_end_reg   <= cfg_wdata;
                default:         range_start_reg <= range_start_reg;
            endcase
        end
    end

    // counter state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg.pos      <= 32'd0;
            state_reg.rate     <= 32'd0;
            state_reg.rem      <= REM_NONE;
            state_reg.dist_lim <= 1'b0;
            state_reg.mode     <= MODE_ONESHOT;
            state_reg.flags    <= 3'b000;
        end else if (advance) begin
            state_reg <= state_next;
        end
    end

    // result register occupancy
    always_comb begin
        out_valid_next = out_valid_reg;
        if (advance) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    // result word
    always_ff @(posedge aclk) begin
        if (advance) begin
            out_data_reg <= {5'b00000,
                             state_next.flags[FLAG_TURN_START],
                             state_next.flags[FLAG_TURN_END],
                             state_next.flags[FLAG_AT_END],
                             state_next.pos};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

// File: verif/animation_frame_counter_top_test.sv
// ----------------------------------------------------------------------------
// animation_frame_counter_top_test
// Self-checking bench for the Q16.16 frame counter. A tracker class mirrors
// position, rate, remaining distance, mode and status flags, predicts the
// result word of every accepted request and checks the words in order. The
// run covers directed corner requests, then phases of random play sequences
// under several ranges, with random gaps and stalls on both streams.
// ----------------------------------------------------------------------------
module animation_frame_counter_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    import afc_pkg::*;

    // result word fields, packed so that frame sits in the lowest bits
    typedef struct packed {
        logic        turned_at_start;
        logic        turned_at_end;
        logic        at_end;
        logic [31:0] frame;
    } frame_word_t;

    class frame_tracker;
        int          pos;
        int          rate;
        int          rem;
        bit          dist_lim;
        logic [1:0]  mode;
        logic [2:0]  flags;
        longint      rs;
        longint      re;
        frame_word_t pending_frames[$];
        int          mismatches;
        int          words_seen;

        function new();
            pos        = 0;
            rate       = 0;
            rem        = REM_NONE;
            dist_lim   = 1'b0;
            mode       = MODE_ONESHOT;
            flags      = '0;
            rs         = 0;
            re         = 0;
            mismatches = 0;
            words_seen = 0;
        endfunction

        function int clamp32(longint v);
            if (v > 64'sh7FFF_FFFF) return 32'h7FFF_FFFF;
            if (v < -64'sh8000_0000) return 32'h8000_0000;
            return int'(v);
        endfunction

        function void set_range(logic index, logic [RANGE_W-1:0] v);
            if (index == CFG_RANGE_START) rs = longint'(v);
            else re = longint'(v);
        endfunction

        // position reached or passed the range end
        function void hit_end();
            case (mode)
                MODE_ONESHOT: begin
                    pos = clamp32(re);
                    flags[FLAG_AT_END] = 1'b1;
                end
                MODE_LOOP: begin
                    flags[FLAG_TURN_END] = 1'b1;
                    pos = clamp32(rs + (longint'(pos) - re));
                end
                MODE_PINGPONG: begin
                    flags[FLAG_TURN_END] = 1'b1;
                    pos  = clamp32(re - (longint'(pos) - re));
                    rate = clamp32(-longint'(rate));
                end
                default: ;
            endcase
        endfunction

        // position fell below the range start
        function void hit_start();
            case (mode)
                MODE_ONESHOT: begin
                    pos = clamp32(rs);
                    flags[FLAG_AT_END] = 1'b1;
                end
                MODE_LOOP: begin
                    pos = clamp32(re);
                    flags[FLAG_TURN_START] = 1'b1;
                end
                MODE_PINGPONG: begin
                    flags[FLAG_TURN_START] = 1'b1;
                    pos  = clamp32(rs - longint'(pos));
                    rate = clamp32(-longint'(rate));
                end
                default: ;
            endcase
        endfunction

        function void advance_tick();
            longint mag;
            flags = '0;
            if (!dist_lim) begin
                pos = clamp32(longint'(pos) + rate);
            end else if (rem > 0) begin
                if (longint'(rem) - rate < 0) begin
                    pos = clamp32(longint'(pos) + rem);
                    rem = 0;
                end else begin
                    mag = (rate > 0) ? longint'(rate) : -longint'(rate);
                    rem = clamp32(longint'(rem) - mag);
                    pos = clamp32(longint'(pos) + rate);
                end
            end
            // a stopped counter still goes through an edge rule
            if (rate == 0) begin
                if (pos >= re) hit_end();
                else hit_start();
            end
            if (rate > 0) begin
                if (pos >= re) hit_end();
            end else if (pos < rs) begin
                hit_start();
            end
        endfunction

        function void begin_play(logic [1:0] pm, int spd);
            mode     = pm;
            rate     = spd;
            dist_lim = 1'b0;
            rem      = REM_NONE;
            flags    = '0;
        endfunction

        // update the state for one accepted request and queue its result word
        function void take_request(logic [3:0] req, logic [1:0] pm, int spd, int val);
            longint      d;
            frame_word_t w;
            case (req)
                REQ_TICK: advance_tick();
                REQ_PLAY: begin
                    begin_play(pm, spd);
                    pos = (spd >= 0) ? clamp32(rs) : clamp32(re);
                end
                REQ_PLAY_CUR: begin_play(pm, spd);
                REQ_PLAY_DIST: begin
                    begin_play(pm, spd);
                    rem      = val;
                    dist_lim = 1'b1;
                end
                REQ_PLAY_TGT: begin
                    begin_play(pm, spd);
                    dist_lim = 1'b1;
                    d   = (spd > 0) ? longint'(val) - pos : longint'(pos) - val;
                    rem = clamp32(d);
                    if (rem < 0) rem = clamp32(longint'(rem) + (re - rs));
                end
                REQ_STOP_HERE: begin
                    flags = '0;
                    rate  = 0;
                end
                REQ_STOP_END: begin
                    rate  = 0;
                    pos   = clamp32(re);
                    flags = '0;
                    flags[FLAG_AT_END] = 1'b1;
                end
                REQ_STOP_AT: begin
                    pos   = val;
                    rate  = 0;
                    flags = '0;
                end
                REQ_SET_FRAME: begin
                    flags = '0;
                    pos   = val;
                end
                default: ;
            endcase
            w.frame           = pos;
            w.at_end          = flags[FLAG_AT_END];
            w.turned_at_end   = flags[FLAG_TURN_END];
            w.turned_at_start = flags[FLAG_TURN_START];
            pending_frames.push_back(w);
        endfunction

        // compare one result word with the oldest queued one
        function void check_word(frame_word_t got);
            frame_word_t want;
            words_seen++;
            if (pending_frames.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("word %0d: result with nothing queued, frame %h flags %b%b%b",
                             words_seen, got.frame, got.turned_at_start,
                             got.turned_at_end, got.at_end);
                return;
            end
            want = pending_frames.pop_front();
            if (got.frame !== want.frame || got.at_end !== want.at_end ||
                got.turned_at_end !== want.turned_at_end ||
                got.turned_at_start !== want.turned_at_start) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("word %0d: expected frame %h end %b tend %b tstart %b, %s %h %b %b %b",
                             words_seen, want.frame, want.at_end, want.turned_at_end,
                             want.turned_at_start, "got", got.frame, got.at_end,
                             got.turned_at_end, got.turned_at_start);
            end
        endfunction
    endclass

    localparam int         Q_ONE            = 32'h0001_0000;
    localparam int         CYCLE_LIMIT      = 200_000;
    // play mode with no edge rule
    localparam logic [1:0] MODE_FREE        = 2'd3;
    // request codes without a function
    localparam logic [3:0] REQ_UNUSED_FIRST = 4'd9;
    localparam logic [3:0] REQ_UNUSED_LAST  = 4'd15;

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata   = '0;
    logic [S_TUSER_W-1:0] s_tuser   = '0;
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 cfg_we    = 1'b0;
    logic                 cfg_index = 1'b0;
    logic [RANGE_W-1:0]   cfg_wdata = '0;

    frame_tracker sb;
    int           requests_sent = 0;
    int           cycles        = 0;
    bit           tx_steady     = 1'b0;

    animation_frame_counter_top dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always #1 aclk = ~aclk;

    // run limit
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // write both range registers, block idle
    task automatic write_range(logic [RANGE_W-1:0] start_q, logic [RANGE_W-1:0] end_q);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_RANGE_START;
        cfg_wdata <= start_q;
        @(posedge aclk);
        sb.set_range(CFG_RANGE_START, start_q);
        cfg_index <= CFG_RANGE_END;
        cfg_wdata <= end_q;
        @(posedge aclk);
        sb.set_range(CFG_RANGE_END, end_q);
        cfg_we    <= 1'b0;
    endtask

    // present one request word and wait for its handshake
    task automatic send_request(logic [3:0] req, logic [1:0] pm, int spd, int val);
        int gap;
        if ($urandom_range(0, 29) == 0) tx_steady = !tx_steady;
        gap = tx_steady ? 0 : $urandom_range(0, 4);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= req;
        s_tdata  <= {6'b0, val, spd, pm};
        do @(posedge aclk); while (!s_tready);
        sb.take_request(req, pm, spd, val);
        requests_sent++;
    endtask

    task automatic send_tick();
        send_request(REQ_TICK, 2'($urandom), $urandom, $urandom);
    endtask

    // stop sending and wait for every queued word
    task automatic hold_until_drained();
        s_tvalid <= 1'b0;
        while (sb.pending_frames.size() != 0) @(posedge aclk);
    endtask

    // corner requests, range 1.0 to 10.0
    task automatic directed_requests();
        send_request(REQ_PLAY, MODE_ONESHOT, Q_ONE / 2, 0);
        send_tick();
        send_request(REQ_PLAY_CUR, MODE_ONESHOT, 5 * Q_ONE, 0);
        send_tick();
        send_tick();
        send_request(REQ_PLAY, MODE_LOOP, -3 * Q_ONE, 0);
        send_tick();
        send_tick();
        send_request(REQ_PLAY, MODE_PINGPONG, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_tick();
        // most negative rate negates to most positive
        send_request(REQ_PLAY_CUR, MODE_PINGPONG, 32'h8000_0000, 32'h8000_0000);
        send_tick();
        send_request(REQ_PLAY_DIST, MODE_LOOP, 2 * Q_ONE, 3 * Q_ONE);
        send_tick();
        send_tick();
        // target behind the position wraps by the range span
        send_request(REQ_PLAY_TGT, MODE_ONESHOT, Q_ONE, 0);
        send_tick();
        send_request(REQ_PLAY_TGT, MODE_PINGPONG, -Q_ONE, 32'h7FFF_FFFF);
        send_request(REQ_PLAY_CUR, MODE_FREE, 32'h7FFF_FFFF, 0);
        send_tick();
        send_request(REQ_STOP_HERE, MODE_ONESHOT, 0, 0);
        send_tick();
        send_request(REQ_STOP_END, MODE_ONESHOT, 0, 0);
        send_request(REQ_STOP_AT, MODE_ONESHOT, 0, 32'h8000_0000);
        send_tick();
        send_request(REQ_SET_FRAME, MODE_ONESHOT, 0, 32'h7FFF_FFFF);
        send_request(REQ_UNUSED_FIRST, 2'($urandom), $urandom, $urandom);
        send_request(REQ_UNUSED_LAST, 2'($urandom), $urandom, $urandom);
    endtask

    function automatic int pick_speed(int span);
        int mag;
        case ($urandom_range(0, 9))
            0: return 0;
            1: return $urandom;
            default: begin
                mag = $urandom_range(1, span / 4 + Q_ONE / 2);
                return $urandom_range(0, 1) ? mag : -mag;
            end
        endcase
    endfunction

    function automatic int pick_value(int lo, int span);
        if ($urandom_range(0, 7) == 0) return $urandom;
        return lo + $urandom_range(0, span);
    endfunction

    // play sequences with random content, some stops and some noise
    task automatic random_run(int start_q, int end_q, int count);
        int         lo;
        int         span;
        int         target;
        int         roll;
        bit         held;
        logic [3:0] req;
        logic [1:0] pm;
        lo     = (start_q < end_q) ? start_q : end_q;
        span   = (start_q < end_q) ? end_q - start_q : start_q - end_q;
        target = requests_sent + count;
        held   = 1'b0;
        while (requests_sent < target) begin
            roll = $urandom_range(0, 9);
            if (roll < 7) begin
                req = 4'($urandom_range(int'(REQ_PLAY), int'(REQ_PLAY_TGT)));
                pm  = ($urandom_range(0, 7) == 0) ? MODE_FREE : 2'($urandom_range(0, 2));
                send_request(req, pm, pick_speed(span),
                             (req == REQ_PLAY_DIST) ? $urandom_range(0, span / 2 + Q_ONE)
                                                    : pick_value(lo, span));
                repeat ($urandom_range(2, 12)) send_tick();
            end else if (roll < 9) begin
                req = 4'($urandom_range(int'(REQ_STOP_HERE), int'(REQ_SET_FRAME)));
                send_request(req, 2'($urandom), $urandom, pick_value(lo, span));
                repeat ($urandom_range(0, 3)) send_tick();
            end else begin
                send_request(4'($urandom), 2'($urandom), $urandom, $urandom);
            end
            // sender holds off once per phase until the pipe is empty
            if (!held && requests_sent >= target - count / 2) begin
                hold_until_drained();
                held = 1'b1;
            end
        end
    endtask

    // result side, random stalls per word
    initial begin : result_sink
        int gap;
        bit rx_steady;
        rx_steady = 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            if ($urandom_range(0, 29) == 0) rx_steady = !rx_steady;
            gap = rx_steady ? 0 : $urandom_range(0, 4);
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            sb.check_word(frame_word_t'(m_tdata[34:0]));
        end
    end

    initial begin : stimulus
        int start_q;
        int end_q;
        sb = new();
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        write_range(RANGE_W'(Q_ONE), RANGE_W'(10 * Q_ONE));
        directed_requests();
        for (int ph = 0; ph < 8; ph++) begin
            case (ph)
                0: begin
                    start_q = 0;
                    end_q   = 32'h7FFF_FFFF;
                end
                1: begin
                    start_q = 32'h7FFF_FFFF;
                    end_q   = 32'h7FFF_FFFF;
                end
                2: begin
                    // inverted range
                    start_q = 10 * Q_ONE;
                    end_q   = 2 * Q_ONE;
                end
                3: begin
                    start_q = 0;
                    end_q   = 0;
                end
                default: begin
                    start_q = $urandom_range(0, 20 * Q_ONE);
                    end_q   = start_q + $urandom_range(Q_ONE, 48 * Q_ONE);
                end
            endcase
            hold_until_drained();
            write_range(start_q[RANGE_W-1:0], end_q[RANGE_W-1:0]);
            random_run(start_q, end_q, 165);
        end
        hold_until_drained();
        repeat (8) @(posedge aclk);
        if (sb.mismatches == 0 && sb.pending_frames.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

// File: filelist.f
hdl/afc_pkg.sv
hdl/afc_in_stage.sv
hdl/afc_step.sv
hdl/animation_frame_counter_top.sv
verif/animation_frame_counter_top_test.sv
